[hw/rtl/ppe_pkg.sv]
// ----------------------------------------------------------------------------
// ppe_pkg
// Shared types, fixed-point constants and the CORDIC arctangent table for
// the pendulum plant step core.
// ----------------------------------------------------------------------------
package ppe_pkg;

   localparam int CORDIC_ITER_DEFAULT = 24;
   localparam int ATAN_IDX_W          = 5;
   localparam int CORDIC_W            = 34;
   localparam int MCAND_W             = 33;
   localparam int MPLIER_W            = 32;
   localparam int PROD_W              = MCAND_W + 1 + MPLIER_W;
   localparam int MUL_CNT_W           = 5;

   localparam logic signed [30:0] ANG_PI      = 31'sd843314857;
   localparam logic signed [30:0] ANG_HALF_PI = 31'sd421657428;
   localparam logic signed [31:0] ANG_TWO_PI  = 32'sd1686629713;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [31:0]        GRAVITY_GAIN_RESET  = 32'd1928724;
   localparam logic [31:0]        TORQUE_GAIN_RESET   = 32'd196608;
   localparam logic [23:0]        TIME_STEP_RESET     = 24'd167772;
   localparam logic signed [30:0] INITIAL_ANGLE_RESET = 31'sd134217728;

   localparam logic [1:0] CSR_GRAVITY_GAIN  = 2'd0;
   localparam logic [1:0] CSR_TORQUE_GAIN   = 2'd1;
   localparam logic [1:0] CSR_TIME_STEP     = 2'd2;
   localparam logic [1:0] CSR_INITIAL_ANGLE = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SINE,
      S_MULG,
      S_MULT,
      S_MULA,
      S_MULR,
      S_WRITE
   } state_type;

   // atan(2^-i) in Q.30
   function automatic logic signed [CORDIC_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [CORDIC_W-1:0] v;
      case (idx)
         5'd0:  v = 34'sd843314856;
         5'd1:  v = 34'sd497837829;
         5'd2:  v = 34'sd263043836;
         5'd3:  v = 34'sd133525158;
         5'd4:  v = 34'sd67021686;
         5'd5:  v = 34'sd33543515;
         5'd6:  v = 34'sd16775850;
         5'd7:  v = 34'sd8388437;
         5'd8:  v = 34'sd4194282;
         5'd9:  v = 34'sd2097149;
         5'd10: v = 34'sd1048575;
         5'd11: v = 34'sd524287;
         5'd12: v = 34'sd262143;
         5'd13: v = 34'sd131071;
         5'd14: v = 34'sd65535;
         5'd15: v = 34'sd32767;
         5'd16: v = 34'sd16383;
         5'd17: v = 34'sd8191;
         5'd18: v = 34'sd4095;
         5'd19: v = 34'sd2047;
         5'd20: v = 34'sd1023;
         5'd21: v = 34'sd511;
         5'd22: v = 34'sd255;
         5'd23: v = 34'sd127;
         5'd24: v = 34'sd63;
         5'd25: v = 34'sd31;
         5'd26: v = 34'sd15;
         5'd27: v = 34'sd7;
         5'd28: v = 34'sd3;
         5'd29: v = 34'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[hw/rtl/ppe_cordic.sv]
// ----------------------------------------------------------------------------
// ppe_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle; sine in Q.30.
// ----------------------------------------------------------------------------
module ppe_cordic #(
   parameter int ITERATIONS = ppe_pkg::CORDIC_ITER_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [30:0]                   angle,
   output logic                                 done,
   output logic signed [ppe_pkg::CORDIC_W-1:0]  sine
);
   import ppe_pkg::*;

   localparam int CW = $clog2(ITERATIONS);

   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in, z_init;
   logic signed [CORDIC_W-1:0] xs, ys, atan_v;
   logic [CW-1:0]              iter_ff;
   logic                       busy_ff, done_ff, last;
   logic signed [32:0]         a_ext, a_fold, hpi_w, pi_w;

   // fold into [-pi/2, pi/2] using sin(pi - x) = sin(x)
   always_comb begin
      a_ext = $signed({{2{angle[30]}}, angle});
      hpi_w = $signed({{2{ANG_HALF_PI[30]}}, ANG_HALF_PI});
      pi_w  = $signed({{2{ANG_PI[30]}}, ANG_PI});
      if (a_ext > hpi_w) begin
         a_fold = pi_w - a_ext;
      end else if (a_ext < -hpi_w) begin
         a_fold = -pi_w - a_ext;
      end else begin
         a_fold = a_ext;
      end
      z_init = {a_fold[31:0], 2'b00};
   end

   always_comb begin
      xs     = x_ff >>> iter_ff;
      ys     = y_ff >>> iter_ff;
      atan_v = atan_q30(ATAN_IDX_W'(iter_ff));
      if (!z_ff[CORDIC_W-1]) begin
         x_in = x_ff - ys;
         y_in = y_ff + xs;
         z_in = z_ff - atan_v;
      end else begin
         x_in = x_ff + ys;
         y_in = y_ff - xs;
         z_in = z_ff + atan_v;
      end
      last = (iter_ff == CW'(ITERATIONS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         iter_ff <= '0;
         x_ff    <= CORDIC_GAIN;
         y_ff    <= '0;
         z_ff    <= z_init;
      end else if (busy_ff) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         iter_ff <= iter_ff + 1'b1;
         if (last) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign sine = y_ff;

endmodule

[hw/rtl/ppe_serial_mult.sv]
// ----------------------------------------------------------------------------
// ppe_serial_mult
// Bit-serial signed-by-unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ppe_serial_mult (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [ppe_pkg::MCAND_W-1:0] mcand,
   input  logic [ppe_pkg::MPLIER_W-1:0]       mplier,
   output logic                               done,
   output logic signed [ppe_pkg::PROD_W-1:0]  product
);
   import ppe_pkg::*;

   logic signed [MCAND_W:0]   hi_ff, sum;
   logic [MPLIER_W-1:0]       lo_ff;
   logic signed [MCAND_W-1:0] mc_ff;
   logic [MUL_CNT_W-1:0]      cnt_ff;
   logic                      busy_ff, done_ff;

   assign sum = hi_ff + (lo_ff[0] ? {mc_ff[MCAND_W-1], mc_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         hi_ff   <= '0;
         lo_ff   <= mplier;
         mc_ff   <= mcand;
      end else if (busy_ff) begin
         hi_ff  <= sum >>> 1;
         lo_ff  <= {sum[0], lo_ff[MPLIER_W-1:1]};
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(MPLIER_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

[hw/rtl/pendulum_plant_euler_step_core.sv]
// ----------------------------------------------------------------------------
// pendulum_plant_euler_step_core
// One semi-implicit Euler step of a rigid-rod pendulum per request word.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word per plant tick: the torque applied in that tick.
//   rsp_* returns one word per request: new angle, rate, acceleration, tick
//   count and a clip flag. Both use valid/ready.
//   csr_* writes the gains, time step and initial angle; writing the
//   initial angle restarts the plant (angle loaded, rate and ticks cleared).
// Sequencing:
//   One word at a time. The sine comes from the iterative CORDIC, then
//   four products share one bit-serial multiplier, then a write state
//   commits the step. The shared multiplier sets the pace per word.
// Reset:
//   Registers return to their defaults, angle to the initial angle, rate
//   and tick count to zero; no response is pending.
// Stall:
//   A finished response sits in the output register; the next request is
//   accepted and computed meanwhile, and its state update waits until the
//   output register is free.
// ----------------------------------------------------------------------------
module pendulum_plant_euler_step_core #(
   parameter int CORDIC_ITERATIONS = ppe_pkg::CORDIC_ITER_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_applied_torque,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [30:0] rsp_angle,
   output logic signed [31:0] rsp_angular_rate,
   output logic signed [31:0] rsp_angular_accel,
   output logic [31:0]        rsp_tick_count,
   output logic               rsp_saturated,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import ppe_pkg::*;

   // configuration and plant state
   logic [31:0]        gravity_gain_ff, torque_gain_ff;
   logic [23:0]        time_step_ff;
   logic signed [30:0] angle_reg_ff;
   logic signed [31:0] rate_reg_ff;
   logic [31:0]        tick_reg_ff;

   // per-word working registers
   logic signed [31:0] torque_ff;
   logic signed [39:0] gterm_ff;
   logic signed [31:0] accel_ff, rate_ff;
   logic               clip_ff;

   // response register
   logic               rsp_valid_ff;
   logic signed [30:0] rsp_angle_ff;
   logic signed [31:0] rsp_rate_ff, rsp_accel_ff;
   logic [31:0]        rsp_tick_ff;
   logic               rsp_sat_ff;

   state_type state_ff, state_in;

   logic                         sin_start, sin_done;
   logic signed [CORDIC_W-1:0]   sine;
   logic                         mul_start, mul_done;
   logic signed [MCAND_W-1:0]    mul_mcand;
   logic [MPLIER_W-1:0]          mul_mplier;
   logic signed [PROD_W-1:0]     prod;

   logic signed [54:0] accel_wide;
   logic signed [31:0] accel_sat;
   logic               accel_clip;
   logic signed [46:0] rate_wide;
   logic signed [31:0] rate_sat;
   logic               rate_clip;
   logic signed [46:0] ang_sum, ang_wrap, ang_fin;
   logic signed [46:0] pi_w, two_pi_w;
   logic               accept, out_free, commit;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign commit   = (state_ff == S_WRITE) && out_free;

   ppe_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (sin_start),
      .angle (angle_reg_ff),
      .done  (sin_done),
      .sine  (sine)
   );

   ppe_serial_mult u_mult (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .done    (mul_done),
      .product (prod)
   );

   // accel = sat32(gterm - (torque_gain*torque >> 12))
   always_comb begin
      accel_wide = {{15{gterm_ff[39]}}, gterm_ff} - {prod[PROD_W-1], prod[PROD_W-1:12]};
      accel_clip = 1'b0;
      if (accel_wide > 55'sd2147483647) begin
         accel_sat  = 32'sh7FFFFFFF;
         accel_clip = 1'b1;
      end else if (accel_wide < -55'sd2147483648) begin
         accel_sat  = 32'sh80000000;
         accel_clip = 1'b1;
      end else begin
         accel_sat = accel_wide[31:0];
      end
   end

   // rate = sat32(rate_reg + (accel*dt >> 20))
   always_comb begin
      rate_wide = {{15{rate_reg_ff[31]}}, rate_reg_ff} + {prod[PROD_W-1], prod[PROD_W-1:20]};
      rate_clip = 1'b0;
      if (rate_wide > 47'sd2147483647) begin
         rate_sat  = 32'sh7FFFFFFF;
         rate_clip = 1'b1;
      end else if (rate_wide < -47'sd2147483648) begin
         rate_sat  = 32'sh80000000;
         rate_clip = 1'b1;
      end else begin
         rate_sat = rate_wide[31:0];
      end
   end

   // angle = angle_reg + (rate*dt >> 20), one 2*pi wrap, then clamp
   always_comb begin
      pi_w     = {{16{ANG_PI[30]}}, ANG_PI};
      two_pi_w = {{15{ANG_TWO_PI[31]}}, ANG_TWO_PI};
      ang_sum  = {{16{angle_reg_ff[30]}}, angle_reg_ff}
               + {prod[PROD_W-1], prod[PROD_W-1:20]};
      if (ang_sum > pi_w) begin
         ang_wrap = ang_sum - two_pi_w;
      end else if (ang_sum < -pi_w) begin
         ang_wrap = ang_sum + two_pi_w;
      end else begin
         ang_wrap = ang_sum;
      end
      if (ang_wrap > pi_w) begin
         ang_fin = pi_w;
      end else if (ang_wrap < -pi_w) begin
         ang_fin = -pi_w;
      end else begin
         ang_fin = ang_wrap;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept)   state_in = S_SINE;
         S_SINE:  if (sin_done) state_in = S_MULG;
         S_MULG:  if (mul_done) state_in = S_MULT;
         S_MULT:  if (mul_done) state_in = S_MULA;
         S_MULA:  if (mul_done) state_in = S_MULR;
         S_MULR:  if (mul_done) state_in = S_WRITE;
         S_WRITE: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // unit starts and multiplier operands
   always_comb begin
      req_ready  = 1'b0;
      sin_start  = 1'b0;
      mul_start  = 1'b0;
      mul_mcand  = '0;
      mul_mplier = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            sin_start = accept;
         end
         S_SINE: begin
            mul_start  = sin_done;
            mul_mcand  = sine[MCAND_W-1:0];
            mul_mplier = gravity_gain_ff;
         end
         S_MULG: begin
            mul_start  = mul_done;
            mul_mcand  = {torque_ff[31], torque_ff};
            mul_mplier = torque_gain_ff;
         end
         S_MULT: begin
            mul_start  = mul_done;
            mul_mcand  = {accel_sat[31], accel_sat};
            mul_mplier = {8'd0, time_step_ff};
         end
         S_MULA: begin
            mul_start  = mul_done;
            mul_mcand  = {rate_sat[31], rate_sat};
            mul_mplier = {8'd0, time_step_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         torque_ff <= req_applied_torque;
      end
      if (state_ff == S_MULG && mul_done) begin
         gterm_ff <= prod[65:26];
      end
      if (state_ff == S_MULT && mul_done) begin
         accel_ff <= accel_sat;
         clip_ff  <= accel_clip;
      end
      if (state_ff == S_MULA && mul_done) begin
         rate_ff <= rate_sat;
         clip_ff <= clip_ff | rate_clip;
      end
   end

   // configuration and plant state; an initial angle write restarts the plant
   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_gain_ff  <= GRAVITY_GAIN_RESET;
         torque_gain_ff   <= TORQUE_GAIN_RESET;
         time_step_ff     <= TIME_STEP_RESET;
         angle_reg_ff     <= INITIAL_ANGLE_RESET;
         rate_reg_ff      <= '0;
         tick_reg_ff      <= '0;
      end else begin
         if (commit) begin
            angle_reg_ff <= ang_fin[30:0];
            rate_reg_ff  <= rate_ff;
            tick_reg_ff  <= tick_reg_ff + 32'd1;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_GRAVITY_GAIN: gravity_gain_ff <= csr_wdata;
               CSR_TORQUE_GAIN:  torque_gain_ff  <= csr_wdata;
               CSR_TIME_STEP:    time_step_ff    <= csr_wdata[23:0];
               CSR_INITIAL_ANGLE: begin
                  angle_reg_ff     <= csr_wdata[30:0];
                  rate_reg_ff      <= '0;
                  tick_reg_ff      <= '0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // output register: load on commit, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_angle_ff <= ang_fin[30:0];
         rsp_rate_ff  <= rate_ff;
         rsp_accel_ff <= accel_ff;
         rsp_tick_ff  <= tick_reg_ff + 32'd1;
         rsp_sat_ff   <= clip_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_angle         = rsp_angle_ff;
   assign rsp_angular_rate  = rsp_rate_ff;
   assign rsp_angular_accel = rsp_accel_ff;
   assign rsp_tick_count    = rsp_tick_ff;
   assign rsp_saturated     = rsp_sat_ff;

endmodule

[hw/rtl/ppe_checker.sv]
// ----------------------------------------------------------------------------
// ppe_checker
// Port-level checks for the pendulum plant step core, bound to the top level.
// ----------------------------------------------------------------------------
module ppe_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [30:0] rsp_angle,
   input logic [31:0]        rsp_tick_count
);
   import ppe_pkg::*;

   // a stalled response stays valid with its angle and tick count held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_angle) && $stable(rsp_tick_count))
      else $error("response word changed while stalled");

   // angle stays wrapped to [-pi, pi]
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_angle <= ANG_PI) && (rsp_angle >= -ANG_PI))
      else $error("angle outside [-pi, pi]");

   // out of reset: idle, nothing pending
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("not idle after reset");

   // a step is not instant: no response right after an accept into an empty output
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("response appeared one cycle after accept");

endmodule

bind pendulum_plant_euler_step_core ppe_checker u_ppe_checker (.*);

[tb/pendulum_plant_euler_step_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pendulum_plant_euler_step_core_tb
// Self-checking bench for the pendulum plant step core. A local fixed-point
// plant model (CORDIC sine, saturating Euler update, single angle wrap)
// predicts every response word. Each response is compared field by field
// against the oldest prediction, under random idling and a long output stall.
// ----------------------------------------------------------------------------
module pendulum_plant_euler_step_core_tb;
   import ppe_pkg::*;

   localparam int  SINE_STEPS  = 24;
   localparam int  WORD_CYCLES = SINE_STEPS + 140;
   localparam int  HOLD_CYCLES = 3000;
   localparam longint PI_Q28   = 843314857;
   localparam longint HPI_Q28  = 421657428;
   localparam longint TPI_Q28  = 1686629713;
   localparam longint ANG_MAX  = 843314856;
   localparam longint I32_MAX  = 64'sd2147483647;
   localparam longint I32_MIN  = -64'sd2147483648;

   typedef struct {
      logic signed [30:0] angle;
      logic signed [31:0] rate;
      logic signed [31:0] accel;
      logic [31:0]        ticks;
      logic               clip;
   } plant_word_type;

   // DUT ports; the inputs are driven to known values from time zero
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_applied_torque = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [30:0] rsp_angle;
   logic signed [31:0] rsp_angular_rate;
   logic signed [31:0] rsp_angular_accel;
   logic [31:0]        rsp_tick_count;
   logic               rsp_saturated;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   // plant model state and register copies
   longint      gain_grav, gain_torq, dt_q24, init_ang, ang_st, rate_st;
   logic [31:0] tick_st;

   plant_word_type plant_expected[$];
   int          mismatches = 0;
   int          words_sent = 0;
   int          words_seen = 0;
   int          clips_seen = 0;
   bit          hold_off = 1'b0;
   bit          quiet = 1'b0;
   event        hold_off_go;

   pendulum_plant_euler_step_core #(.CORDIC_ITERATIONS(SINE_STEPS)) u_top (
      .clock, .reset,
      .req_valid, .req_ready, .req_applied_torque,
      .rsp_valid, .rsp_ready, .rsp_angle, .rsp_angular_rate, .rsp_angular_accel,
      .rsp_tick_count, .rsp_saturated,
      .csr_we, .csr_index, .csr_wdata
   );

   always #1 clock = ~clock;

   // hard stop well beyond the slowest legal run
   initial begin
      #6000000;
      $display("TIMEOUT: run did not drain");
      $display("CHECKS FAILED");
      $finish;
   end

   // ------------------------------------------------------------------ model
   function automatic longint sine_q30(input longint ang);
      longint x, y, z, xs, ys, a;
      x = 652032874;
      y = 0;
      a = ang;
      // fold into [-pi/2, pi/2] with sin(pi - x) = sin(x)
      if (a > HPI_Q28) a = PI_Q28 - a;
      else if (a < -HPI_Q28) a = -PI_Q28 - a;
      z = a * 4;
      for (int i = 0; i < SINE_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= longint'(atan_q30(i[4:0]));
         end else begin
            x += ys; y -= xs; z += longint'(atan_q30(i[4:0]));
         end
      end
      return y;
   endfunction

   function automatic longint clip32(input longint v, inout bit hit);
      if (v > I32_MAX) begin hit = 1'b1; return I32_MAX; end
      if (v < I32_MIN) begin hit = 1'b1; return I32_MIN; end
      return v;
   endfunction

   // advance the plant by one tick and return the word it should report
   function automatic plant_word_type euler_tick(input logic signed [31:0] torque);
      plant_word_type w;
      bit     hit;
      longint gterm, tterm, acc, rate, ang;
      hit   = 1'b0;
      gterm = (gain_grav * sine_q30(ang_st)) >>> 26;
      tterm = (gain_torq * longint'(torque)) >>> 12;
      acc   = clip32(gterm - tterm, hit);
      rate  = clip32(rate_st + ((acc * dt_q24) >>> 20), hit);
      ang   = ang_st + ((rate * dt_q24) >>> 20);
      // one wrap, then clamp whatever is still out of range
      if (ang > PI_Q28) ang -= TPI_Q28;
      else if (ang < -PI_Q28) ang += TPI_Q28;
      if (ang > PI_Q28) ang = PI_Q28;
      else if (ang < -PI_Q28) ang = -PI_Q28;
      ang_st  = ang;
      rate_st = rate;
      tick_st = tick_st + 1;
      w.angle = ang[30:0];
      w.rate  = rate[31:0];
      w.accel = acc[31:0];
      w.ticks = tick_st;
      w.clip  = hit;
      return w;
   endfunction

   // ------------------------------------------------------------ stimulus
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_GRAVITY_GAIN: gain_grav = longint'(val);
         CSR_TORQUE_GAIN:  gain_torq = longint'(val);
         CSR_TIME_STEP:    dt_q24    = longint'(val[23:0]);
         CSR_INITIAL_ANGLE: begin
            // restart the plant
            init_ang = longint'($signed(val[30:0]));
            ang_st   = init_ang;
            rate_st  = 0;
            tick_st  = '0;
         end
         default: begin
         end
      endcase
   endtask

   task automatic load_plant(input longint g, input longint t, input longint dt,
                             input longint a0);
      csr_write(CSR_GRAVITY_GAIN, g[31:0]);
      csr_write(CSR_TORQUE_GAIN, t[31:0]);
      csr_write(CSR_TIME_STEP, dt[31:0]);
      csr_write(CSR_INITIAL_ANGLE, a0[31:0]);
   endtask

   // offer one torque word; valid stays high unless an idle gap is taken
   task automatic send_torque(input logic signed [31:0] torque);
      if (!quiet && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_applied_torque <= torque;
      do @(posedge clock); while (!req_ready);
      plant_expected.push_back(euler_tick(torque));
      words_sent++;
   endtask

   // drop valid, let every response arrive, then settle before any CSR write
   task automatic drain;
      req_valid <= 1'b0;
      while (plant_expected.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_torque();
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return $signed($urandom_range(0, 131072)) - 65536;
         default: return $signed($urandom_range(0, 2097152)) - 1048576;
      endcase
   endfunction

   function automatic longint rand_angle();
      return longint'($urandom_range(0, 2 * ANG_MAX)) - ANG_MAX;
   endfunction

   // ------------------------------------------------------------- tests
   task automatic test_reset_values;
      // plant runs from its reset registers without any CSR write
      send_torque(32'sd0);
      send_torque(32'sd65536);
      send_torque(-32'sd65536);
      drain();
   endtask

   task automatic test_directed_extremes;
      load_plant(0, 0, 1, 0);
      send_torque(32'sh7fffffff);
      send_torque(32'sh80000000);
      drain();
      // hard torque, huge step: accel and rate clip, angle runs past one wrap
      load_plant(64'hffffffff, 64'hffffffff, 64'hffffff, ANG_MAX);
      send_torque(32'sh80000000);
      send_torque(32'sh7fffffff);
      send_torque(-32'sd1);
      send_torque(32'sd1);
      drain();
      load_plant(64'hffffffff, 0, 64'hffffff, -ANG_MAX);
      send_torque(32'sd0);
      send_torque(32'sd0);
      drain();
      // zero step: angle and rate hold
      load_plant(1928724, 196608, 0, HPI_Q28);
      send_torque(32'sh12345678);
      send_torque(32'sh0000ffff);
      drain();
      // sine fold points around +/- pi/2 and the pi edges
      load_plant(1928724, 196608, 1, HPI_Q28 + 1);
      send_torque(32'sd0);
      drain();
      csr_write(CSR_INITIAL_ANGLE, 32'(-(HPI_Q28 + 1)));
      send_torque(32'sd0);
      drain();
      csr_write(CSR_INITIAL_ANGLE, 32'(-ANG_MAX));
      send_torque(32'sh55555555);
      send_torque(32'shaaaaaaaa);
      drain();
      csr_write(CSR_INITIAL_ANGLE, 32'h3fffffff);
      send_torque(32'sd0);
      drain();
   endtask

   task automatic run_random_phase(input int n, input bit wild);
      longint g, t, dt;
      g  = wild ? longint'($urandom) : longint'($urandom_range(0, 4000000));
      t  = wild ? longint'($urandom) : longint'($urandom_range(0, 600000));
      dt = wild ? longint'($urandom_range(0, 24'hffffff))
                : longint'($urandom_range(1, 1000000));
      load_plant(g, t, dt, rand_angle());
      for (int i = 0; i < n; i++) send_torque(rand_torque());
      drain();
   endtask

   task automatic test_random_plants;
      for (int p = 0; p < 8; p++) run_random_phase(45, p % 3 == 2);
   endtask

   task automatic test_steady_stream;
      // no idling anywhere: back to back words
      quiet = 1'b1;
      run_random_phase(60, 1'b0);
      quiet = 1'b0;
   endtask

   task automatic test_output_stall;
      // hold the response side off long enough that the core stops taking words
      -> hold_off_go;
      run_random_phase(50, 1'b0);
   endtask

   task automatic test_tick_restart;
      // initial angle rewrite restarts ticks mid run
      run_random_phase(30, 1'b0);
      csr_write(CSR_INITIAL_ANGLE, 32'd0);
      for (int i = 0; i < 30; i++) send_torque(rand_torque());
      drain();
   endtask

   // ---------------------------------------------------------- checking
   task automatic report(input string field, input longint got, input longint want);
      $display("MISMATCH %s at response %0d: got %0d expected %0d",
               field, words_seen, got, want);
      mismatches++;
   endtask

   // long receiver hold-off, counted in cycles
   always begin
      @(hold_off_go);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // drive ready with random stalls and the long hold-off; check each word
   always @(posedge clock) begin
      plant_word_type w;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            words_seen++;
            if (plant_expected.size() == 0) begin
               report("unexpected response", 0, 0);
            end else begin
               w = plant_expected.pop_front();
               if (w.clip) clips_seen++;
               if (rsp_angle !== w.angle) report("angle", rsp_angle, w.angle);
               if (rsp_angular_rate !== w.rate)
                  report("angular_rate", rsp_angular_rate, w.rate);
               if (rsp_angular_accel !== w.accel)
                  report("angular_accel", rsp_angular_accel, w.accel);
               if (rsp_tick_count !== w.ticks)
                  report("tick_count", rsp_tick_count, w.ticks);
               if (rsp_saturated !== w.clip)
                  report("saturated", rsp_saturated, w.clip);
            end
         end
         if (hold_off) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet || ($urandom_range(0, 99) >= 7);
         end
      end
   end

   // ------------------------------------------------------------- main
   initial begin
      gain_grav = 1928724;
      gain_torq = 196608;
      dt_q24    = 167772;
      init_ang  = 134217728;
      ang_st    = init_ang;
      rate_st   = 0;
      tick_st   = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_directed_extremes();
      test_random_plants();
      test_steady_stream();
      test_output_stall();
      test_tick_restart();

      // catch any stray words after the last expectation
      repeat (WORD_CYCLES) @(posedge clock);
      $display("Covered %0d torque words and %0d responses, %0d of them clipped,",
               words_sent, words_seen, clips_seen);
      $display("across directed extremes, random plants, a steady stream and a long stall.");
      if (mismatches == 0 && plant_expected.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches,
                  plant_expected.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/ppe_pkg.sv
hw/rtl/ppe_cordic.sv
hw/rtl/ppe_serial_mult.sv
hw/rtl/pendulum_plant_euler_step_core.sv
hw/rtl/ppe_checker.sv
tb/pendulum_plant_euler_step_core_tb.sv
